// File: sv/srb_pkg.sv
package srb_pkg;

	// field widths fixed by the stream format
	localparam int CMD_W      = 3;
	localparam int SMP_W      = 32;
	localparam int CH_W       = 3;
	localparam int LEN_W      = 6;
	localparam int DIST_W     = 11;
	localparam int STS_W      = 2;
	localparam int LAG_W      = 32;
	localparam int CAP_W      = 11;
	localparam int MASK_W     = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 11;

	localparam int CHANNELS   = 8;
	localparam int CAP_RESET  = 1024;
	localparam logic [MASK_W-1:0] MASK_RESET = 8'hFF;

	// s_tdata layout, lowest bit up: sample, channel, read_length, preamble, distance
	localparam int OFS_CH     = 32;
	localparam int OFS_LEN    = 35;
	localparam int OFS_PRE    = 41;
	localparam int OFS_DIST   = 47;
	localparam int IN_DATA_W  = 64;

	// m_tdata layout, lowest bit up: status, data_out, lag
	localparam int OFS_DATA   = 2;
	localparam int OFS_LAG    = 34;
	localparam int OUT_DATA_W = 72;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK = 8'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WR_CHECKED   = 3'd0,
		CMD_WR_UNCHECKED = 3'd1,
		CMD_BLOCK_READ   = 3'd2,
		CMD_FAST_FWD     = 3'd3,
		CMD_LAG_QUERY    = 3'd4
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK       = 2'd0,
		STS_FULL     = 2'd1,
		STS_SHORT    = 2'd2,
		STS_DISABLED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_NORM_WI,
		S_NORM_RI,
		S_FF_MOD,
		S_RD_MOD,
		S_RD_STREAM
	} state_t;

	typedef enum logic [1:0] {
		MOD_WI,
		MOD_RI,
		MOD_PRE,
		MOD_DIST
	} mod_sel_t;

	typedef enum logic [1:0] {
		OP_SIMPLE,
		OP_FF,
		OP_READ
	} op_t;

	typedef struct packed {
		logic     clear_en;
		logic     accept;
		logic     mod_start;
		mod_sel_t mod_sel;
		logic     norm_clear;
		logic     norm_wi_load;
		logic     norm_ri_load;
		logic     ff_apply;
		logic     rd_setup;
		logic     stream_en;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic norm_pending;
		logic mod_done;
		logic fifo_room;
		logic inflight;
		op_t  op;
		logic issue_last;
	} dp_status_t;

	typedef struct packed {
		logic [LAG_W-1:0] lag;
		logic [SMP_W-1:0] data;
		logic             last;
		status_t          status;
	} out_item_t;

endpackage

// File: sv/srb_mod.sv
module srb_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [srb_pkg::CAP_W-1:0] dividend,
	input  logic [srb_pkg::CAP_W-1:0] divisor,
	output logic                      done,
	output logic [srb_pkg::CAP_W-1:0] rem
);
	import srb_pkg::*;

	localparam int CNT_W = $clog2(CAP_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CAP_W-1:0] r_q;
	logic [CAP_W-1:0] sh_q;
	logic [CAP_W:0]   trial;
	logic [CAP_W-1:0] r_next;
	logic             fast;

	// restoring remainder, one dividend bit per cycle; r_q < divisor keeps trial < 2*divisor
	always_comb begin
		trial  = {r_q, sh_q[CAP_W-1]};
		r_next = (trial >= {1'b0, divisor}) ? CAP_W'(trial - {1'b0, divisor})
			: trial[CAP_W-1:0];
		fast   = dividend < divisor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !fast;
				done_q <= fast;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CAP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q  <= fast ? dividend : '0;
			sh_q <= dividend;
		end else if (busy_q) begin
			r_q  <= r_next;
			sh_q <= sh_q << 1;
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

// File: sv/srb_datapath.sv
module srb_datapath #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srb_pkg::ctrl_cmd_t             cmd,
	output srb_pkg::dp_status_t            status,
	input  logic [srb_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [srb_pkg::CMD_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [srb_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [srb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import srb_pkg::*;

	localparam int IW    = $clog2(DEPTH);
	localparam int XW    = (IW < CAP_W) ? IW : CAP_W;
	localparam int CNT_W = $clog2(2 * MAX_BURST + 1);
	localparam logic [CAP_W-1:0] CAP_RST = CAP_W'((DEPTH < CAP_RESET) ? DEPTH : CAP_RESET);
	localparam logic [1:0] OQ_FULL = 2'd2;

	function automatic logic [CAP_W-1:0] back_wrap(input logic [CAP_W-1:0] a,
			input logic [CAP_W-1:0] r, input logic [CAP_W-1:0] c);
		logic [CAP_W:0] s;
		s = {1'b0, a} + {1'b0, c} - {1'b0, r};
		if (s >= {1'b0, c})
			s = s - {1'b0, c};
		return s[CAP_W-1:0];
	endfunction

	function automatic logic [CAP_W-1:0] inc_wrap(input logic [CAP_W-1:0] a,
			input logic [CAP_W-1:0] c);
		logic [CAP_W:0] s;
		s = {1'b0, a} + 1'b1;
		return (s == {1'b0, c}) ? '0 : s[CAP_W-1:0];
	endfunction

	// input fields
	logic [CMD_W-1:0]  cmd_in;
	logic [SMP_W-1:0]  smp_in;
	logic [CH_W-1:0]   ch_in;
	logic [LEN_W-1:0]  len_in;
	logic [LEN_W-1:0]  pre_in;
	logic [DIST_W-1:0] dist_in;
	logic [LEN_W-1:0]  len_sat;
	logic [LEN_W-1:0]  pre_sat;
	logic [CNT_W-1:0]  total_in;
	logic              enabled;
	logic              is_full;
	logic              is_short;

	// configuration
	logic [CAP_W-1:0]  cap_q;
	logic [MASK_W-1:0] mask_q;
	logic              pending_q;
	logic [CAP_W-1:0]  cap_wr;
	logic              cap_write;

	// ring state; *_raw_q keep the last stored index, wi_q/ri_q that index mod capacity
	logic [XW-1:0]     wi_q, wi_raw_q, ri_q, ri_raw_q;
	logic [XW-1:0]     wi_d, wi_raw_d, ri_d, ri_raw_d;
	logic [LAG_W-1:0]  fill_q, fill_d;
	logic [CNT_W-1:0]  total_q;
	logic [DIST_W-1:0] dist_q;

	// memory and clear sweep
	logic [SMP_W-1:0]  mem [DEPTH];
	logic [IW-1:0]     clr_q;
	logic              mem_we;
	logic [IW-1:0]     waddr;
	logic [SMP_W-1:0]  wdata;

	// burst read
	logic [XW-1:0]     pos_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              issue;
	logic              issue_last;
	logic [XW-1:0]     pos_inc;
	logic              v_s1;
	logic              last_s1;
	logic [SMP_W-1:0]  rdata_s1;

	// modulo unit
	logic [CAP_W-1:0]  mod_x;
	logic              mod_done;
	logic [CAP_W-1:0]  mod_rem;

	// output queue
	out_item_t         ent_q [2];
	logic              wptr_q, rptr_q;
	logic [1:0]        count_q;
	logic              push_imm;
	status_t           imm_sts;
	logic              push;
	logic              pop;
	out_item_t         push_item;
	out_item_t         head;

	op_t               op;

	always_comb begin
		cmd_in   = s_tuser;
		smp_in   = s_tdata[SMP_W-1:0];
		ch_in    = s_tdata[OFS_CH +: CH_W];
		len_in   = s_tdata[OFS_LEN +: LEN_W];
		pre_in   = s_tdata[OFS_PRE +: LEN_W];
		dist_in  = s_tdata[OFS_DIST +: DIST_W];
		len_sat  = (len_in > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : len_in;
		pre_sat  = (pre_in > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : pre_in;
		total_in = CNT_W'(len_sat) + CNT_W'(pre_sat);
		enabled  = (32'(ch_in) < CHANNELS) && mask_q[ch_in];
		is_full  = fill_q >= LAG_W'(cap_q);
		is_short = fill_q < LAG_W'(len_sat);
	end

	always_comb begin
		case (cmd_in)
			CMD_BLOCK_READ: op = (!is_short && total_in != '0) ? OP_READ : OP_SIMPLE;
			CMD_FAST_FWD:   op = OP_FF;
			default:        op = OP_SIMPLE;
		endcase
	end

	// configuration port
	always_comb begin
		cap_wr = cfg_data[CAP_W-1:0];
		if (cap_wr == '0)
			cap_wr = CAP_W'(1);
		else if (32'(cap_wr) > DEPTH)
			cap_wr = CAP_W'(DEPTH);
		cap_write = cfg_valid && (cfg_index == REG_CAPACITY);
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RST;
			mask_q    <= MASK_RESET;
			pending_q <= 1'b0;
		end else begin
			if (cap_write)
				cap_q <= cap_wr;
			if (cfg_valid && cfg_index == REG_CHANNEL_MASK)
				mask_q <= cfg_data[MASK_W-1:0];
			if (cap_write)
				pending_q <= 1'b1;
			else if (cmd.norm_clear)
				pending_q <= 1'b0;
		end
	end

	// modulo operand select
	always_comb begin
		case (cmd.mod_sel)
			MOD_WI:   mod_x = CAP_W'(wi_raw_q);
			MOD_RI:   mod_x = CAP_W'(ri_raw_q);
			MOD_PRE:  mod_x = CAP_W'(pre_sat);
			MOD_DIST: mod_x = CAP_W'(dist_in);
			default:  mod_x = '0;
		endcase
	end

	srb_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (mod_x),
		.divisor  (cap_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// burst issue: queue slots minus the read in flight, counting this cycle's pop
	always_comb begin
		pop        = m_tvalid && m_tready;
		issue      = cmd.stream_en && (cnt_q != '0)
			&& ((3'(count_q) + 3'(v_s1)) < (3'd2 + 3'(pop)));
		issue_last = issue && (cnt_q == CNT_W'(1));
		pos_inc    = XW'(inc_wrap(CAP_W'(pos_q), cap_q));
	end

	// per-item state update
	always_comb begin
		wi_d     = wi_q;
		wi_raw_d = wi_raw_q;
		ri_d     = ri_q;
		ri_raw_d = ri_raw_q;
		fill_d   = fill_q;
		push_imm = 1'b0;
		imm_sts  = STS_OK;
		mem_we   = 1'b0;
		if (cmd.accept) begin
			case (cmd_in)
				CMD_WR_CHECKED, CMD_WR_UNCHECKED: begin
					push_imm = 1'b1;
					if (!enabled) begin
						imm_sts = STS_DISABLED;
					end else if (cmd_in == CMD_WR_CHECKED && is_full) begin
						imm_sts = STS_FULL;
					end else begin
						mem_we   = 1'b1;
						wi_d     = XW'(inc_wrap(CAP_W'(wi_q), cap_q));
						wi_raw_d = wi_d;
						if (fill_q != '1)
							fill_d = fill_q + 1'b1;
					end
				end
				CMD_BLOCK_READ: begin
					if (is_short) begin
						push_imm = 1'b1;
						imm_sts  = STS_SHORT;
					end else begin
						fill_d = fill_q - LAG_W'(len_sat);
						// empty read still stores the read point reduced to the capacity
						if (total_in == '0) begin
							push_imm = 1'b1;
							ri_raw_d = ri_q;
						end
					end
				end
				CMD_FAST_FWD: begin
				end
				default: push_imm = 1'b1;
			endcase
		end
		if (cmd.ff_apply) begin
			ri_d     = XW'(back_wrap(CAP_W'(wi_q), mod_rem, cap_q));
			ri_raw_d = ri_d;
			fill_d   = LAG_W'(dist_q);
			push_imm = 1'b1;
		end
		if (cmd.norm_wi_load)
			wi_d = XW'(mod_rem);
		if (cmd.norm_ri_load)
			ri_d = XW'(mod_rem);
		if (issue_last) begin
			ri_d     = pos_inc;
			ri_raw_d = pos_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q     <= '0;
			wi_raw_q <= '0;
			ri_q     <= '0;
			ri_raw_q <= '0;
			fill_q   <= '0;
			clr_q    <= '0;
			cnt_q    <= '0;
			v_s1     <= 1'b0;
		end else begin
			wi_q     <= wi_d;
			wi_raw_q <= wi_raw_d;
			ri_q     <= ri_d;
			ri_raw_q <= ri_raw_d;
			fill_q   <= fill_d;
			if (cmd.clear_en)
				clr_q <= clr_q + 1'b1;
			if (cmd.rd_setup)
				cnt_q <= total_q;
			else if (issue)
				cnt_q <= cnt_q - 1'b1;
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			total_q <= total_in;
			dist_q  <= dist_in;
		end
		if (cmd.rd_setup)
			pos_q <= XW'(back_wrap(CAP_W'(ri_q), mod_rem, cap_q));
		else if (issue)
			pos_q <= pos_inc;
		last_s1 <= issue_last;
	end

	// sample store: one write port, one registered read port
	always_comb begin
		waddr = cmd.clear_en ? clr_q : IW'(wi_q);
		wdata = cmd.clear_en ? '0 : smp_in;
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en || mem_we)
			mem[waddr] <= wdata;
		if (issue)
			rdata_s1 <= mem[IW'(pos_q)];
	end

	// two-entry output queue
	always_comb begin
		push = push_imm || v_s1;
		if (v_s1) begin
			push_item.lag    = fill_q;
			push_item.data   = rdata_s1;
			push_item.last   = last_s1;
			push_item.status = STS_OK;
		end else begin
			push_item.lag    = fill_d;
			push_item.data   = '0;
			push_item.last   = 1'b1;
			push_item.status = imm_sts;
		end
		head = ent_q[rptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= !wptr_q;
			if (pop)
				rptr_q <= !rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wptr_q] <= push_item;
	end

	assign m_tvalid = count_q != '0;
	assign m_tdata  = OUT_DATA_W'({head.lag, head.data, head.status});
	assign m_tlast  = head.last;

	always_comb begin
		status.clear_last   = clr_q == IW'(DEPTH - 1);
		status.norm_pending = pending_q;
		status.mod_done     = mod_done;
		status.fifo_room    = count_q < OQ_FULL;
		status.inflight     = v_s1;
		status.op           = op;
		status.issue_last   = issue_last;
	end

endmodule

// File: sv/srb_ctrl.sv
module srb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  srb_pkg::dp_status_t status,
	output srb_pkg::ctrl_cmd_t  cmd
);
	import srb_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE) && !status.norm_pending && status.fifo_room
		&& !status.inflight;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (status.clear_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (status.norm_pending) begin
					state_d = S_NORM_WI;
				end else if (accept) begin
					case (status.op)
						OP_FF:   state_d = S_FF_MOD;
						OP_READ: state_d = S_RD_MOD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			// a new capacity write during renormalization restarts it
			S_NORM_WI: begin
				if (status.norm_pending)
					state_d = S_IDLE;
				else if (status.mod_done)
					state_d = S_NORM_RI;
			end
			S_NORM_RI: begin
				if (status.norm_pending || status.mod_done)
					state_d = S_IDLE;
			end
			S_FF_MOD: begin
				if (status.mod_done)
					state_d = S_IDLE;
			end
			S_RD_MOD: begin
				if (status.mod_done)
					state_d = S_RD_STREAM;
			end
			S_RD_STREAM: begin
				if (status.issue_last)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR: cmd.clear_en = 1'b1;
			S_IDLE: begin
				if (status.norm_pending) begin
					cmd.mod_start  = 1'b1;
					cmd.mod_sel    = MOD_WI;
					cmd.norm_clear = 1'b1;
				end else if (accept) begin
					cmd.accept = 1'b1;
					if (status.op == OP_FF) begin
						cmd.mod_start = 1'b1;
						cmd.mod_sel   = MOD_DIST;
					end else if (status.op == OP_READ) begin
						cmd.mod_start = 1'b1;
						cmd.mod_sel   = MOD_PRE;
					end
				end
			end
			S_NORM_WI: begin
				if (!status.norm_pending && status.mod_done) begin
					cmd.norm_wi_load = 1'b1;
					cmd.mod_start    = 1'b1;
					cmd.mod_sel      = MOD_RI;
				end
			end
			S_NORM_RI: begin
				if (!status.norm_pending && status.mod_done)
					cmd.norm_ri_load = 1'b1;
			end
			S_FF_MOD: begin
				if (status.mod_done)
					cmd.ff_apply = 1'b1;
			end
			S_RD_MOD: begin
				if (status.mod_done)
					cmd.rd_setup = 1'b1;
			end
			S_RD_STREAM: cmd.stream_en = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

endmodule

// File: sv/sample_ring_buffer_with_preamble.sv
// Sample ring buffer with preamble read. After reset the sample store is swept
// to zero, one slot per cycle; s_tready stays low meanwhile (configuration
// writes are taken at any time). Writes, lag queries, refused writes and short
// reads are accepted every cycle while the two-entry output queue is drained.
// A fast forward waits for the bit-serial remainder unit, which takes a short
// path when the distance is below the capacity. A block read takes the same
// remainder step for the preamble, then streams preamble + read_length results
// at one per cycle from the registered memory read port while the output queue
// has room. A capacity write runs both ring indices through the remainder unit
// before the next item is taken.
module sample_ring_buffer_with_preamble #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// sample[31:0], channel[34:32], read_length[40:35], preamble[46:41], distance[57:47]
	input  logic [srb_pkg::IN_DATA_W-1:0]  s_tdata,
	// command[2:0]
	input  logic [srb_pkg::CMD_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status[1:0], data_out[33:2], lag[65:34]
	output logic [srb_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [srb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import srb_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	srb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	srb_datapath #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

// File: sv/srb_checker.sv
module srb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [srb_pkg::CMD_W-1:0]      s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [srb_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [srb_pkg::CFG_IDX_W-1:0]  cfg_index
);
	import srb_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// error results are single, closing transactions with no sample
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[STS_W-1:0] != STS_OK)
		|-> m_tlast && (m_tdata[OFS_DATA +: SMP_W] == '0))
		else $error("error result not last or carries data");

	// fast forward needs the remainder step before the next item
	a_ff_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_FAST_FWD) |=> !s_tready)
		else $error("item taken during fast forward");

	// capacity change renormalizes the indices before the next item
	a_cap_norm: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_CAPACITY) |=> !s_tready)
		else $error("item taken before index renormalization");

endmodule

bind sample_ring_buffer_with_preamble srb_checker u_srb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tuser   (s_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index)
);

// File: tb/sample_ring_buffer_with_preamble_tb.sv
module sample_ring_buffer_with_preamble_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srb_pkg::*;

	localparam int RING_DEPTH = 1024;
	localparam int BURST_MAX  = 32;

	// command codes the block treats as no-ops
	localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

	typedef struct {
		logic [CMD_W-1:0]  op;
		logic [SMP_W-1:0]  smp;
		logic [CH_W-1:0]   ch;
		logic [LEN_W-1:0]  rd_len;
		logic [LEN_W-1:0]  pre_len;
		logic [DIST_W-1:0] ff_dist;
	} ring_cmd_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY
	} rx_mode_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [CMD_W-1:0]      s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// shadow of the ring
	logic [SMP_W-1:0]      ring [RING_DEPTH];
	int unsigned           wr_ptr    = 0;
	int unsigned           rd_ptr    = 0;
	logic [LAG_W-1:0]      lag_count = '0;
	int unsigned           ring_cap  = CAP_RESET;
	logic [MASK_W-1:0]     ch_mask   = MASK_RESET;

	ring_cmd_t             feed [$];
	out_item_t             due [$];
	int                    err_count = 0;

	int                    burst_left = 0;
	int                    gap_left   = 0;
	rx_mode_t              rx_mode    = RX_OPEN;
	int                    rx_left    = 0;

	sample_ring_buffer_with_preamble #(
		.DEPTH(RING_DEPTH),
		.MAX_BURST(BURST_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[sample_ring_buffer_with_preamble] ERROR");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		if (err_count < 40)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		err_count++;
	endtask

	function automatic void push_result(input status_t st, input logic [SMP_W-1:0] d,
			input logic lst);
		out_item_t r;
		r.status = st;
		r.data   = d;
		r.last   = lst;
		r.lag    = lag_count;
		due.push_back(r);
	endfunction

	function automatic void ring_predict(input logic [CMD_W-1:0] op,
			input logic [IN_DATA_W-1:0] d);
		logic [SMP_W-1:0] smp;
		logic [CH_W-1:0]  ch;
		int unsigned      rl, pl, fd, cap, w, r, base, total, i;
		smp = d[SMP_W-1:0];
		ch  = d[OFS_CH +: CH_W];
		rl  = d[OFS_LEN +: LEN_W];
		pl  = d[OFS_PRE +: LEN_W];
		fd  = d[OFS_DIST +: DIST_W];
		cap = (ring_cap == 0) ? 1 : ((ring_cap > RING_DEPTH) ? RING_DEPTH : ring_cap);
		w   = wr_ptr % cap;
		r   = rd_ptr % cap;
		case (op)
			CMD_WR_CHECKED, CMD_WR_UNCHECKED: begin
				if (!ch_mask[ch])
					push_result(STS_DISABLED, '0, 1'b1);
				else if (op == CMD_WR_CHECKED && lag_count >= cap)
					push_result(STS_FULL, '0, 1'b1);
				else begin
					ring[w] = smp;
					wr_ptr = (w + 1) % cap;
					if (lag_count != 32'hFFFF_FFFF)
						lag_count++;
					push_result(STS_OK, '0, 1'b1);
				end
			end
			CMD_BLOCK_READ: begin
				if (rl > BURST_MAX)
					rl = BURST_MAX;
				if (pl > BURST_MAX)
					pl = BURST_MAX;
				if (lag_count < rl)
					push_result(STS_SHORT, '0, 1'b1);
				else begin
					total = pl + rl;
					base = (r + cap - (pl % cap)) % cap;
					lag_count -= rl;
					rd_ptr = (r + rl) % cap;
					if (total == 0)
						push_result(STS_OK, '0, 1'b1);
					for (i = 0; i < total; i++)
						push_result(STS_OK, ring[(base + i) % cap], i + 1 == total);
				end
			end
			CMD_FAST_FWD: begin
				rd_ptr = (w + cap - (fd % cap)) % cap;
				lag_count = fd;
				push_result(STS_OK, '0, 1'b1);
			end
			default: begin
				push_result(STS_OK, '0, 1'b1);
			end
		endcase
	endfunction

	task automatic check_result();
		out_item_t want;
		if (due.size() == 0) begin
			report("result with nothing outstanding, lag", m_tdata[OFS_LAG +: LAG_W], '0);
			return;
		end
		want = due.pop_front();
		if (m_tdata[STS_W-1:0] != want.status)
			report("status", m_tdata[STS_W-1:0], want.status);
		if (m_tdata[OFS_DATA +: SMP_W] != want.data)
			report("data_out", m_tdata[OFS_DATA +: SMP_W], want.data);
		if (m_tlast != want.last)
			report("last", m_tlast, want.last);
		if (m_tdata[OFS_LAG +: LAG_W] != want.lag)
			report("lag", m_tdata[OFS_LAG +: LAG_W], want.lag);
	endtask

	// results are checked before the same edge's input is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				ring_predict(s_tuser, s_tdata);
		end
	end

	always @(posedge clk or negedge arst_n) begin : drive
		ring_cmd_t nxt;
		logic      v;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			v = s_tvalid && !s_tready;
			if (!v) begin
				if (gap_left != 0)
					gap_left--;
				else if (feed.size() != 0) begin
					nxt = feed.pop_front();
					s_tuser <= nxt.op;
					s_tdata <= {6'b0, nxt.ff_dist, nxt.pre_len, nxt.rd_len, nxt.ch, nxt.smp};
					v = 1'b1;
					if (burst_left != 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(0, 15);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			s_tvalid <= v;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode <= RX_OPEN;
			rx_left <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 2));
				rx_left <= $urandom_range(10, 60);
			end else
				rx_left <= rx_left - 1;
			case (rx_mode)
				RX_OPEN:  m_tready <= 1'b1;
				RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
				default:  m_tready <= ($urandom_range(0, 1) != 0);
			endcase
		end
	end

	function automatic ring_cmd_t mk(input logic [CMD_W-1:0] op, input logic [SMP_W-1:0] smp,
			input logic [CH_W-1:0] ch, input logic [LEN_W-1:0] rl, input logic [LEN_W-1:0] pl,
			input logic [DIST_W-1:0] fd);
		ring_cmd_t c;
		c.op      = op;
		c.smp     = smp;
		c.ch      = ch;
		c.rd_len  = rl;
		c.pre_len = pl;
		c.ff_dist = fd;
		return c;
	endfunction

	function automatic ring_cmd_t rand_cmd();
		ring_cmd_t   c;
		int unsigned pick;
		c.smp = $urandom;
		c.ch = CH_W'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		if (pick < 30)
			c.op = CMD_WR_CHECKED;
		else if (pick < 52)
			c.op = CMD_WR_UNCHECKED;
		else if (pick < 80)
			c.op = CMD_BLOCK_READ;
		else if (pick < 88)
			c.op = CMD_FAST_FWD;
		else if (pick < 95)
			c.op = CMD_LAG_QUERY;
		else
			c.op = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
		// mostly short bursts, now and then the full field range
		if ($urandom_range(0, 7) == 0) begin
			c.rd_len = LEN_W'($urandom);
			c.pre_len = LEN_W'($urandom);
		end else begin
			c.rd_len = LEN_W'($urandom_range(0, 6));
			c.pre_len = LEN_W'($urandom_range(0, 4));
		end
		c.ff_dist = ($urandom_range(0, 5) == 0) ? DIST_W'($urandom)
			: DIST_W'($urandom_range(0, 12));
		return c;
	endfunction

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_CAPACITY)
			ring_cap = val;
		else
			ch_mask = val[MASK_W-1:0];
		@(posedge clk);
	endtask

	task automatic settle();
		do @(posedge clk); while (feed.size() != 0 || s_tvalid || due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] cap, input logic [MASK_W-1:0] mask,
			input int n);
		set_reg(REG_CAPACITY, cap);
		set_reg(REG_CHANNEL_MASK, mask);
		repeat (n) feed.push_back(rand_cmd());
		settle();
	endtask

	initial begin : stimulus
		foreach (ring[i])
			ring[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small ring, channel 7 off
		set_reg(REG_CAPACITY, 11'd4);
		set_reg(REG_CHANNEL_MASK, 11'h07F);
		feed.push_back(mk(CMD_LAG_QUERY, '0, 0, 0, 0, 0));
		feed.push_back(mk(CMD_BLOCK_READ, '0, 0, 1, 0, 0));
		feed.push_back(mk(CMD_BLOCK_READ, '0, 0, 0, 0, 0));
		feed.push_back(mk(CMD_WR_CHECKED, 32'hFFFF_FFFF, 0, 0, 0, 0));
		feed.push_back(mk(CMD_WR_CHECKED, 32'h1234_5678, 7, 0, 0, 0));
		feed.push_back(mk(CMD_WR_UNCHECKED, 32'h8765_4321, 7, 0, 0, 0));
		feed.push_back(mk(CMD_WR_CHECKED, 32'h0000_0000, 1, 0, 0, 0));
		feed.push_back(mk(CMD_WR_CHECKED, 32'hA5A5_A5A5, 2, 0, 0, 0));
		feed.push_back(mk(CMD_WR_CHECKED, 32'h5A5A_5A5A, 3, 0, 0, 0));
		feed.push_back(mk(CMD_WR_CHECKED, 32'hDEAD_BEEF, 4, 0, 0, 0));
		feed.push_back(mk(CMD_WR_UNCHECKED, 32'h0F0F_0F0F, 6, 0, 0, 0));
		feed.push_back(mk(CMD_BLOCK_READ, '0, 0, 2, 3, 0));
		feed.push_back(mk(CMD_BLOCK_READ, '0, 0, 6'h3F, 6'h3F, 0));
		feed.push_back(mk(CMD_FAST_FWD, '0, 0, 0, 0, 11'h7FF));
		feed.push_back(mk(CMD_BLOCK_READ, '1, 7, 6'h3F, 6'h3F, 11'h7FF));
		feed.push_back(mk(CMD_BLOCK_READ, '0, 0, 0, 5, 0));
		feed.push_back(mk(CMD_FAST_FWD, '0, 0, 0, 0, 0));
		feed.push_back(mk(CMD_BLOCK_READ, '0, 0, 0, 0, 0));
		feed.push_back(mk(CMD_RSVD_FIRST, 32'hCAFE_F00D, 5, 6'h15, 6'h2A, 11'h555));
		feed.push_back(mk(CMD_RSVD_LAST, '1, 7, 6'h3F, 6'h3F, 11'h7FF));
		feed.push_back(mk(CMD_FAST_FWD, '0, 0, 0, 0, 11'd1024));
		feed.push_back(mk(CMD_LAG_QUERY, '1, 7, 6'h3F, 6'h3F, 11'h7FF));
		feed.push_back(mk(CMD_WR_UNCHECKED, 32'h1357_9BDF, 5, 0, 0, 0));
		feed.push_back(mk(CMD_WR_CHECKED, 32'h2468_ACE0, 5, 0, 0, 0));
		settle();

		// capacity 0 behaves as a single slot, above the depth as the full depth
		run_phase(11'd0, 8'hFF, 35);
		run_phase(11'h7FF, MASK_W'($urandom), 45);
		run_phase(11'd1, 8'h00, 15);
		run_phase(CFG_DATA_W'($urandom_range(2, 16)), 8'hFF, 48);
		run_phase(11'd1024, MASK_W'($urandom), 43);

		repeat (30) @(posedge clk);
		while (due.size() != 0) begin
			report("missing result, lag", '0, due[0].lag);
			void'(due.pop_front());
		end
		if (err_count == 0)
			$display("[sample_ring_buffer_with_preamble] OK");
		else
			$display("[sample_ring_buffer_with_preamble] ERROR");
		$finish;
	end

endmodule

// File: files.f
sv/srb_pkg.sv
sv/srb_mod.sv
sv/srb_datapath.sv
sv/srb_ctrl.sv
sv/sample_ring_buffer_with_preamble.sv
sv/srb_checker.sv
tb/sample_ring_buffer_with_preamble_tb.sv
